### sv/utcl_pkg.sv
// shared types, constants and calendar helpers for the utc to local time converter
`default_nettype none

package utcl_pkg;

    // fixed time and calendar constants
    localparam int DAY_SECS  = 86400;
    localparam int HOUR_SECS = 3600;
    localparam int ERA_DAYS  = 146097;
    localparam int YEAR_DAYS = 365;

    // reset value of the utc offset register (-3 hours)
    localparam logic signed [4:0] OFFSET_RESET = -5'sd3;

    // input transaction payload
    typedef struct packed {
        logic        utc_valid;
        logic [11:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic [5:0]  utc_second;
    } utcl_in_t;

    // result transaction payload
    typedef struct packed {
        logic        local_valid;
        logic [11:0] local_year;
        logic [3:0]  local_month;
        logic [4:0]  local_day;
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
        logic [5:0]  local_second;
    } utcl_out_t;

    // day index split into 400-year era and day of era
    typedef struct packed {
        logic signed [4:0]  era;
        logic signed [18:0] doe;
    } utcl_day_t;

    // local time of day
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } utcl_hms_t;

    // local calendar date
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } utcl_date_t;

    // first day of a march-based month, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            4'd12:   res = 9'd367;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // whole centuries in a year of era (0..399)
    function automatic logic [1:0] century(input logic [8:0] yoe);
        logic [1:0] res;
        if (yoe >= 9'd300)
            res = 2'd3;
        else if (yoe >= 9'd200)
            res = 2'd2;
        else if (yoe >= 9'd100)
            res = 2'd1;
        else
            res = 2'd0;
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/utcl_days.sv
// date to era and day of era, days-from-civil in three stages
`default_nettype none

module utcl_days
    import utcl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [11:0] year,
    input  wire logic [3:0]  month,
    input  wire logic [4:0]  day,
    output utcl_day_t        days
);

    localparam int YR_SHIFT = 24;
    localparam int YR_RECIP = (1 << YR_SHIFT) / 400;

    // stage 1
    logic               early;
    logic [12:0]        ys_full;
    logic [3:0]         mp;
    logic signed [9:0]  doy1_next;
    logic [27:0]        yprod_next;
    logic [27:0]        yprod_reg;
    logic [11:0]        ys_reg;
    logic               neg_reg;
    logic signed [9:0]  doy1_reg;

    always_comb
    begin
        early      = (month <= 4'd2);
        ys_full    = {1'b0, year} - {12'b0, early};
        mp         = early ? (month + 4'd9) : (month - 4'd3);
        doy1_next  = $signed({1'b0, month_start(mp)}) + $signed({5'b0, day}) - 10'sd1;
        yprod_next = 28'(ys_full[11:0]) * 28'(YR_RECIP);
    end

    always_ff @(posedge clk)
    begin
        yprod_reg <= yprod_next;
        ys_reg    <= ys_full[11:0];
        neg_reg   <= ys_full[12];
        doy1_reg  <= doy1_next;
    end

    // stage 2: era and year of era with one correction step
    logic [3:0]         q0;
    logic [12:0]        yr_rem;
    logic               yr_fix;
    logic signed [4:0]  era2_next;
    logic [8:0]         yoe_next;
    logic signed [4:0]  era2_reg;
    logic [8:0]         yoe_reg;
    logic signed [9:0]  doy2_reg;

    always_comb
    begin
        q0     = yprod_reg[27:YR_SHIFT];
        yr_rem = {1'b0, ys_reg} - 13'(q0) * 13'd400;
        yr_fix = (yr_rem >= 13'd400);
        if (neg_reg)
        begin
            era2_next = -5'sd1;
            yoe_next  = 9'd399;
        end
        else
        begin
            era2_next = $signed(5'(q0) + 5'(yr_fix));
            yoe_next  = yr_fix ? 9'(yr_rem - 13'd400) : 9'(yr_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        era2_reg <= era2_next;
        yoe_reg  <= yoe_next;
        doy2_reg <= doy1_reg;
    end

    // stage 3: day of era
    logic [17:0]        doe_base;
    utcl_day_t          days_next;
    utcl_day_t          days_reg;

    always_comb
    begin
        doe_base      = 18'(yoe_reg) * 18'(YEAR_DAYS) + 18'(yoe_reg[8:2])
                      - 18'(century(yoe_reg));
        days_next.era = era2_reg;
        days_next.doe = $signed({1'b0, doe_base}) + 19'(doy2_reg);
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
    end

    assign days = days_reg;

endmodule

`default_nettype wire

### sv/utcl_clock.sv
// time of day plus offset, day carry and split into hour, minute, second
`default_nettype none

module utcl_clock
    import utcl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [4:0]        hour,
    input  wire logic [5:0]        minute,
    input  wire logic [5:0]        second,
    input  wire logic signed [4:0] offset,
    output logic signed [1:0]      adj,
    output utcl_hms_t              hms
);

    localparam int H_SHIFT = 24;
    localparam int H_RECIP = (1 << H_SHIFT) / HOUR_SECS;
    localparam int M_SHIFT = 16;
    localparam int M_RECIP = (1 << M_SHIFT) / 60;

    // stage 1: seconds relative to utc midnight
    logic signed [6:0]  hs;
    logic [18:0]        ms;
    logic signed [18:0] tod_next;
    logic signed [18:0] tod_reg;

    always_comb
    begin
        hs       = $signed({2'b0, hour}) + 7'(offset);
        ms       = 19'(minute) * 19'd60 + 19'(second);
        tod_next = 19'(hs) * 19'sd3600 + $signed(ms);
    end

    always_ff @(posedge clk)
    begin
        tod_reg <= tod_next;
    end

    // stage 2: borrow or carry a day, start hour division
    logic signed [1:0]  adj_next;
    logic signed [18:0] rem_full;
    logic [16:0]        rem_next;
    logic [29:0]        hprod_next;
    logic signed [1:0]  adj2_reg;
    logic [16:0]        rem_reg;
    logic [29:0]        hprod_reg;

    always_comb
    begin
        if (tod_reg < 19'sd0)
        begin
            adj_next = -2'sd1;
            rem_full = tod_reg + 19'sd86400;
        end
        else if (tod_reg >= 19'sd86400)
        begin
            adj_next = 2'sd1;
            rem_full = tod_reg - 19'sd86400;
        end
        else
        begin
            adj_next = 2'sd0;
            rem_full = tod_reg;
        end
        rem_next   = rem_full[16:0];
        hprod_next = 30'(rem_next) * 30'(H_RECIP);
    end

    always_ff @(posedge clk)
    begin
        adj2_reg  <= adj_next;
        rem_reg   <= rem_next;
        hprod_reg <= hprod_next;
    end

    // stage 3: hour with correction
    logic [5:0]         h0;
    logic [16:0]        hr_rem;
    logic               hr_fix;
    logic signed [1:0]  adj3_reg;
    logic [4:0]         hr3_reg;
    logic [11:0]        r13_reg;

    always_comb
    begin
        h0     = hprod_reg[29:H_SHIFT];
        hr_rem = rem_reg - 17'(h0) * 17'(HOUR_SECS);
        hr_fix = (hr_rem >= 17'(HOUR_SECS));
    end

    always_ff @(posedge clk)
    begin
        adj3_reg <= adj2_reg;
        hr3_reg  <= 5'(h0) + 5'(hr_fix);
        r13_reg  <= hr_fix ? 12'(hr_rem - 17'(HOUR_SECS)) : 12'(hr_rem);
    end

    // stage 4: start minute division
    logic [22:0]        mprod_reg;
    logic [4:0]         hr4_reg;
    logic [11:0]        r14_reg;

    always_ff @(posedge clk)
    begin
        mprod_reg <= 23'(r13_reg) * 23'(M_RECIP);
        hr4_reg   <= hr3_reg;
        r14_reg   <= r13_reg;
    end

    // stage 5: minute and second with correction
    logic [6:0]         m0;
    logic [11:0]        sec_rem;
    logic               mn_fix;
    utcl_hms_t          hms_next;
    utcl_hms_t          hms_reg;

    always_comb
    begin
        m0              = mprod_reg[22:M_SHIFT];
        sec_rem         = r14_reg - 12'(m0) * 12'd60;
        mn_fix          = (sec_rem >= 12'd60);
        hms_next.hour   = hr4_reg;
        hms_next.minute = 6'(m0) + 6'(mn_fix);
        hms_next.second = mn_fix ? 6'(sec_rem - 12'd60) : 6'(sec_rem);
    end

    always_ff @(posedge clk)
    begin
        hms_reg <= hms_next;
    end

    assign adj = adj3_reg;
    assign hms = hms_reg;

endmodule

`default_nettype wire

### sv/utcl_civil.sv
// era and day of era plus day carry back to year, month, day (civil-from-days)
`default_nettype none

module utcl_civil
    import utcl_pkg::*;
(
    input  wire logic              clk,
    input  wire utcl_day_t         days,
    input  wire logic signed [1:0] adj,
    output utcl_date_t             date
);

    localparam int Q_SHIFT   = 20;
    localparam int R1460     = (1 << Q_SHIFT) / 1460;
    localparam int R365      = (1 << Q_SHIFT) / YEAR_DAYS;

    // stage 1: apply day carry, renormalize into the era
    logic signed [18:0] d1;
    logic signed [4:0]  era1_next;
    logic signed [18:0] doe1_full;
    logic signed [4:0]  era1_reg;
    logic [17:0]        doe1_reg;

    always_comb
    begin
        d1 = days.doe + 19'(adj);
        if (d1 < 19'sd0)
        begin
            era1_next = days.era - 5'sd1;
            doe1_full = d1 + 19'(ERA_DAYS);
        end
        else if (d1 >= 19'(ERA_DAYS))
        begin
            era1_next = days.era + 5'sd1;
            doe1_full = d1 - 19'(ERA_DAYS);
        end
        else
        begin
            era1_next = days.era;
            doe1_full = d1;
        end
    end

    always_ff @(posedge clk)
    begin
        era1_reg <= era1_next;
        doe1_reg <= doe1_full[17:0];
    end

    // stage 2: leap corrections, four-year division started
    logic [2:0]         cent_cnt;
    logic [1:0]         cadj_next;
    logic signed [4:0]  era2_reg;
    logic [17:0]        doe2_reg;
    logic [27:0]        p1460_reg;
    logic [1:0]         cadj_reg;

    always_comb
    begin
        cent_cnt  = 3'(doe1_reg >= 18'd36524) + 3'(doe1_reg >= 18'd73048)
                  + 3'(doe1_reg >= 18'd109572) + 3'(doe1_reg >= 18'd146096);
        cadj_next = 2'(cent_cnt - 3'(doe1_reg == 18'd146096));
    end

    always_ff @(posedge clk)
    begin
        era2_reg  <= era1_reg;
        doe2_reg  <= doe1_reg;
        p1460_reg <= 28'(doe1_reg) * 28'(R1460);
        cadj_reg  <= cadj_next;
    end

    // stage 3: finish the four-year quotient
    logic [7:0]         q1460;
    logic [17:0]        r1460;
    logic [17:0]        q4;
    logic signed [4:0]  era3_reg;
    logic [17:0]        doe3_reg;
    logic [17:0]        x3_reg;

    always_comb
    begin
        q1460 = p1460_reg[27:Q_SHIFT];
        r1460 = doe2_reg - 18'(q1460) * 18'd1460;
        q4    = 18'(q1460) + 18'(r1460 >= 18'd1460);
    end

    always_ff @(posedge clk)
    begin
        era3_reg <= era2_reg;
        doe3_reg <= doe2_reg;
        x3_reg   <= doe2_reg - q4 + 18'(cadj_reg);
    end

    // stage 4: start year division
    logic signed [4:0]  era4_reg;
    logic [17:0]        doe4_reg;
    logic [17:0]        x4_reg;
    logic [29:0]        p365_reg;

    always_ff @(posedge clk)
    begin
        era4_reg <= era3_reg;
        doe4_reg <= doe3_reg;
        x4_reg   <= x3_reg;
        p365_reg <= 30'(x3_reg) * 30'(R365);
    end

    // stage 5: year of era
    logic [9:0]         y0;
    logic [17:0]        ry;
    logic signed [4:0]  era5_reg;
    logic [17:0]        doe5_reg;
    logic [8:0]         yoe5_reg;

    always_comb
    begin
        y0 = p365_reg[29:Q_SHIFT];
        ry = x4_reg - 18'(y0) * 18'(YEAR_DAYS);
    end

    always_ff @(posedge clk)
    begin
        era5_reg <= era4_reg;
        doe5_reg <= doe4_reg;
        yoe5_reg <= 9'(y0 + 10'(ry >= 18'(YEAR_DAYS)));
    end

    // stage 6: day of march-based year
    logic [17:0]        ystart;
    logic signed [4:0]  era6_reg;
    logic [8:0]         yoe6_reg;
    logic [8:0]         doy6_reg;

    always_comb
    begin
        ystart = 18'(yoe5_reg) * 18'(YEAR_DAYS) + 18'(yoe5_reg[8:2])
               - 18'(century(yoe5_reg));
    end

    always_ff @(posedge clk)
    begin
        era6_reg <= era5_reg;
        yoe6_reg <= yoe5_reg;
        doy6_reg <= 9'(doe5_reg - ystart);
    end

    // stage 7: month by parallel compare against month starts
    logic [3:0]         mp_next;
    logic signed [4:0]  era7_reg;
    logic [8:0]         yoe7_reg;
    logic [8:0]         doy7_reg;
    logic [3:0]         mp7_reg;

    always_comb
    begin
        mp_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            mp_next = mp_next + 4'(doy6_reg >= month_start(4'(k)));
        end
    end

    always_ff @(posedge clk)
    begin
        era7_reg <= era6_reg;
        yoe7_reg <= yoe6_reg;
        doy7_reg <= doy6_reg;
        mp7_reg  <= mp_next;
    end

    // output: calendar fields, registered by the caller
    logic [3:0]         mon;
    logic signed [13:0] yr_full;

    always_comb
    begin
        mon        = (mp7_reg < 4'd10) ? (mp7_reg + 4'd3) : (mp7_reg - 4'd9);
        yr_full    = 14'(era7_reg) * 14'sd400 + $signed(14'(yoe7_reg))
                   + $signed(14'(mon <= 4'd2));
        date.year  = yr_full[11:0];
        date.month = mon;
        date.day   = 5'(doy7_reg - month_start(mp7_reg) + 9'd1);
    end

endmodule

`default_nettype wire

### sv/utc_to_local_civil_time_core.sv
// top level of the utc to local civil time converter
`default_nettype none

// channel    | ports                                      | handshake
// -----------+--------------------------------------------+---------------------------
// request    | start, busy, utc_time                      | taken when start && !busy
// result     | done, local_time                           | one-cycle strobe on done
// register   | psel penable pwrite paddr pwdata prdata    | apb, written on access
//            | pready                                     | phase, pready tied high
//
// a transaction can be taken every cycle while busy is low; its result shows on done
// once the date has gone to a day index, back to a date and through the output
// register; the time-of-day path runs alongside and is delayed to match
// busy is high during reset and in the first cycle after it; no clearing pass
// the receiver cannot stall, so the pipeline never holds and results leave in order

module utc_to_local_civil_time_core
    import utcl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire utcl_in_t    utc_time,
    // result channel
    output logic             done,
    output utcl_out_t        local_time,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // pipeline depth from accept to the civil date being ready
    localparam int LAT     = 10;
    // extra delay for the time-of-day path to line up with the date
    localparam int HMS_DLY = 5;
    // word index of the offset register
    localparam logic REG_OFFSET = 1'b0;

    // -------------------------------------------------------------------
    // register port: offset register
    // -------------------------------------------------------------------
    logic                 cfg_wr;
    logic signed [4:0]    offset_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_OFFSET))
        begin
            offset_reg <= $signed(pwdata[4:0]);
        end
    end

    // reads return the sign-extended offset, zero past the register map
    always_comb
    begin
        unique case (paddr[2])
            REG_OFFSET: prdata = 32'(offset_reg);
            default:    prdata = 32'd0;
        endcase
    end

    // -------------------------------------------------------------------
    // request acceptance and transaction tracking
    // -------------------------------------------------------------------
    logic                 accept;
    logic                 busy_reg;
    logic [LAT-1:0]       act_reg;
    logic [LAT-1:0]       act_next;
    logic [LAT-1:0]       ok_reg;
    logic [LAT-1:0]       ok_next;

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // active and input-valid flags travel alongside the datapath
    always_comb
    begin
        act_next = {act_reg[LAT-2:0], accept};
        ok_next  = {ok_reg[LAT-2:0], utc_time.utc_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            act_reg  <= '0;
            ok_reg   <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            act_reg  <= act_next;
            ok_reg   <= ok_next;
        end
    end

    // -------------------------------------------------------------------
    // datapath
    // -------------------------------------------------------------------
    utcl_day_t            days;
    logic signed [1:0]    adj;
    utcl_hms_t            hms;
    utcl_date_t           date;

    // date to era / day of era, 3 stages
    utcl_days u_days (
        .clk   (clk),
        .year  (utc_time.utc_year),
        .month (utc_time.utc_month),
        .day   (utc_time.utc_day),
        .days  (days)
    );

    // time of day with offset; day carry after 3 stages, hh:mm:ss after 5
    utcl_clock u_clock (
        .clk    (clk),
        .hour   (utc_time.utc_hour),
        .minute (utc_time.utc_minute),
        .second (utc_time.utc_second),
        .offset (offset_reg),
        .adj    (adj),
        .hms    (hms)
    );

    // day index plus carry back to a calendar date, 7 stages
    utcl_civil u_civil (
        .clk  (clk),
        .days (days),
        .adj  (adj),
        .date (date)
    );

    // align hh:mm:ss with the date
    utcl_hms_t            hms_dly_reg [HMS_DLY];

    always_ff @(posedge clk)
    begin
        hms_dly_reg[0] <= hms;
        for (int i = 1; i < HMS_DLY; i++)
        begin
            hms_dly_reg[i] <= hms_dly_reg[i-1];
        end
    end

    // -------------------------------------------------------------------
    // output register; invalid requests give an all-zero result
    // -------------------------------------------------------------------
    utcl_out_t            result_next;
    utcl_out_t            result_reg;
    logic                 done_reg;

    always_comb
    begin
        if (ok_reg[LAT-1])
        begin
            result_next.local_valid  = 1'b1;
            result_next.local_year   = date.year;
            result_next.local_month  = date.month;
            result_next.local_day    = date.day;
            result_next.local_hour   = hms_dly_reg[HMS_DLY-1].hour;
            result_next.local_minute = hms_dly_reg[HMS_DLY-1].minute;
            result_next.local_second = hms_dly_reg[HMS_DLY-1].second;
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= act_reg[LAT-1];
    end

    assign done       = done_reg;
    assign local_time = result_reg;

    // -------------------------------------------------------------------
    // assertions
    // -------------------------------------------------------------------

    // every accepted transaction gives exactly one result, and no result comes without one
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy, LAT + 1))
        else $error("result strobe out of step with accepted transactions");

    // an invalid result carries no stale date or time
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !local_time.local_valid) |->
        (local_time.local_year == 12'd0 && local_time.local_month == 4'd0 &&
         local_time.local_day == 5'd0 && local_time.local_hour == 5'd0 &&
         local_time.local_minute == 6'd0 && local_time.local_second == 6'd0))
        else $error("invalid result with nonzero fields");

    // the split back into calendar and clock fields always lands in range
    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && local_time.local_valid) |->
        (local_time.local_month >= 4'd1 && local_time.local_month <= 4'd12 &&
         local_time.local_day >= 5'd1 && local_time.local_hour <= 5'd23 &&
         local_time.local_minute <= 6'd59 && local_time.local_second <= 6'd59))
        else $error("converted field out of range");

endmodule

`default_nettype wire

### sim/utcl_checker.sv
// checker for the utc to local civil time converter: predicts each result and compares it
module utcl_checker
    import utcl_pkg::*;
#(
    parameter logic [2:0] OFFSET_ADDR = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  utcl_in_t    utc_time,
    input  logic        done,
    input  utcl_out_t   local_time,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          err_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint EPOCH_SHIFT = 719468;

    logic signed [4:0] offset_hours;
    utcl_out_t         local_expected[$];
    int                result_index;

    initial err_count = 0;

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // date to day count, add time and offset, split, day count back to date
    function automatic utcl_out_t convert_to_local(input utcl_in_t t,
                                                   input logic signed [4:0] offs);
        utcl_out_t r;
        longint    y, m, d, era, yoe, mp, doy, doe, days, secs, rem, z;
        r = '0;
        if (!t.utc_valid)
            return r;
        y = t.utc_year;
        m = t.utc_month;
        d = t.utc_day;
        if (m <= 2)
            y = y - 1;
        era  = floor_quot(y, 400);
        yoe  = y - era * 400;
        mp   = (m > 2) ? m - 3 : m + 9;
        doy  = (153 * mp + 2) / 5 + d - 1;
        doe  = yoe * YEAR_DAYS + yoe / 4 - yoe / 100 + doy;
        days = era * ERA_DAYS + doe - EPOCH_SHIFT;

        secs = days * DAY_SECS + longint'(t.utc_hour) * HOUR_SECS
             + longint'(t.utc_minute) * 60 + longint'(t.utc_second)
             + longint'(offs) * HOUR_SECS;
        days = floor_quot(secs, DAY_SECS);
        rem  = secs - days * DAY_SECS;

        z   = days + EPOCH_SHIFT;
        era = floor_quot(z, ERA_DAYS);
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / YEAR_DAYS;
        doy = doe - (YEAR_DAYS * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);

        r.local_valid  = 1'b1;
        r.local_year   = y[11:0];
        r.local_month  = m[3:0];
        r.local_day    = d[4:0];
        r.local_hour   = 5'(rem / HOUR_SECS);
        r.local_minute = 6'((rem % HOUR_SECS) / 60);
        r.local_second = 6'(rem % 60);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        err_count = err_count + 1;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      result_index, name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        utcl_out_t want;
        if (!rst_n)
        begin
            offset_hours = OFFSET_RESET;
            local_expected.delete();
            result_index = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (local_expected.size() == 0)
                    report_mismatch($sformatf("result %0d with none expected", result_index));
                else
                begin
                    want = local_expected.pop_front();
                    check_field("local_valid", int'(local_time.local_valid),
                                int'(want.local_valid));
                    check_field("local_year", int'(local_time.local_year),
                                int'(want.local_year));
                    check_field("local_month", int'(local_time.local_month),
                                int'(want.local_month));
                    check_field("local_day", int'(local_time.local_day),
                                int'(want.local_day));
                    check_field("local_hour", int'(local_time.local_hour),
                                int'(want.local_hour));
                    check_field("local_minute", int'(local_time.local_minute),
                                int'(want.local_minute));
                    check_field("local_second", int'(local_time.local_second),
                                int'(want.local_second));
                end
                result_index = result_index + 1;
            end
            if (start && !busy)
                local_expected.push_back(convert_to_local(utc_time, offset_hours));
            if (psel && penable && pwrite && pready && paddr == OFFSET_ADDR)
                offset_hours = pwdata[4:0];
            pending <= local_expected.size();
        end
    end
endmodule

### sim/tb.sv
// testbench top for the utc to local civil time converter: stimulus, register writes, verdict
module tb;
    import utcl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // offset register is the only one, index 0 at byte address 0
    localparam logic [2:0] OFFSET_ADDR = 3'd0;
    // edge that takes a transaction to its done strobe
    localparam int PIPE_DEPTH   = 11;
    localparam int MAX_GAP      = 18;
    localparam int PHASE_ITEMS  = 196;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    utcl_in_t    utc_time = '0;
    logic        done;
    utcl_out_t   local_time;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int err_count;
    int pending;
    int cycle_count = 0;
    int burst_left = 0;

    always #6 clk = ~clk;

    utc_to_local_civil_time_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .utc_time   (utc_time),
        .done       (done),
        .local_time (local_time),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // the checker sees every channel the block has but the read data, and does all prediction
    utcl_checker #(.OFFSET_ADDR(OFFSET_ADDR)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .utc_time   (utc_time),
        .done       (done),
        .local_time (local_time),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .err_count  (err_count),
        .pending    (pending)
    );

    // hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("utc_to_local_civil_time_core regression: fail");
            $finish;
        end
    end

    function automatic utcl_in_t stamp(input logic v, input int y, input int m, input int d,
                                       input int h, input int mi, input int s);
        utcl_in_t t;
        t.utc_valid  = v;
        t.utc_year   = 12'(y);
        t.utc_month  = 4'(m);
        t.utc_day    = 5'(d);
        t.utc_hour   = 5'(h);
        t.utc_minute = 6'(mi);
        t.utc_second = 6'(s);
        return t;
    endfunction

    // present one transaction, hold start until the block takes it, then idle for a random gap that may be none
    task automatic send_stamp(input utcl_in_t t);
        int gap;
        utc_time <= t;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // bursts of back-to-back transactions between stretches of random gaps
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mostly plausible timestamps, leaning on month ends and times near midnight
    task automatic send_random_stamp();
        logic [63:0] raw;
        int          d, h;
        if ($urandom_range(0, 99) < 15)
        begin
            // any bit pattern, out of range fields included
            raw = {$urandom, $urandom};
            send_stamp(raw[$bits(utcl_in_t)-1:0]);
        end
        else
        begin
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 31) : $urandom_range(1, 28);
            h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 23)
              : (($urandom_range(0, 1) == 0) ? $urandom_range(0, 2) : $urandom_range(20, 23));
            send_stamp(stamp($urandom_range(0, 19) != 0, $urandom_range(2000, 2099),
                             $urandom_range(1, 12), d, h, $urandom_range(0, 59),
                             $urandom_range(0, 59)));
        end
    endtask

    // let every expected result come back, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_offset(input logic signed [4:0] hours);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= OFFSET_ADDR;
        pwdata  <= {{27{hours[4]}}, hours};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic signed [4:0] offsets[$];
        int                i;
        offsets = '{5'sd14, -5'sd12, 5'sd15, -5'sd16, 5'sd0, 5'sd1, -5'sd1};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed transactions under the reset offset of -3 hours
        send_stamp(stamp(1'b0, 4095, 15, 31, 31, 63, 63));      // invalid with all ones
        send_stamp(stamp(1'b0, 0, 0, 0, 0, 0, 0));              // invalid, all zero
        send_stamp(stamp(1'b1, 2000, 1, 1, 0, 0, 0));           // rolls back into 1999
        send_stamp(stamp(1'b1, 2099, 12, 31, 23, 59, 59));      // last second of range
        send_stamp(stamp(1'b1, 2000, 3, 1, 1, 30, 0));          // back to feb 29 of 2000
        send_stamp(stamp(1'b1, 2001, 3, 1, 2, 0, 0));           // back to feb 28
        send_stamp(stamp(1'b1, 2096, 2, 29, 12, 0, 0));         // leap day itself
        send_stamp(stamp(1'b1, 2024, 1, 1, 2, 59, 59));         // new year borrow
        send_stamp(stamp(1'b1, 2050, 0, 15, 10, 0, 0));         // month zero
        send_stamp(stamp(1'b1, 2050, 13, 15, 10, 0, 0));        // month past december
        send_stamp(stamp(1'b1, 2050, 14, 29, 10, 0, 0));
        send_stamp(stamp(1'b1, 2050, 15, 31, 10, 0, 0));
        send_stamp(stamp(1'b1, 2050, 5, 0, 10, 0, 0));          // day zero
        send_stamp(stamp(1'b1, 2050, 2, 31, 10, 0, 0));         // day past month end
        send_stamp(stamp(1'b1, 2050, 6, 30, 31, 63, 63));       // oversized time of day
        send_stamp(stamp(1'b1, 0, 1, 1, 0, 0, 0));              // year zero, negative result
        send_stamp(stamp(1'b1, 0, 0, 0, 0, 0, 0));
        send_stamp(stamp(1'b1, 4095, 15, 31, 31, 63, 63));      // every field at its top
        send_stamp(stamp(1'b1, 2099, 12, 31, 20, 59, 59));
        send_stamp(stamp(1'b1, 2000, 12, 31, 21, 0, 0));
        for (i = 0; i < PHASE_ITEMS; i++)
            send_random_stamp();
        drain();

        // one phase per offset, extremes and a random value among them
        offsets.push_back(5'($urandom_range(0, 31)));
        foreach (offsets[k])
        begin
            write_offset(offsets[k]);
            // last second of 2099 and first of 2000, to roll the day forward or back at this offset
            send_stamp(stamp(1'b1, 2099, 12, 31, 23, 59, 59));
            send_stamp(stamp(1'b1, 2000, 1, 1, 0, 0, 0));
            for (i = 0; i < PHASE_ITEMS; i++)
                send_random_stamp();
            drain();
        end

        if (err_count == 0)
            $display("utc_to_local_civil_time_core regression: pass");
        else
            $display("utc_to_local_civil_time_core regression: fail");
        $finish;
    end
endmodule
